>>> src/vpcs_pkg.sv
// ----------------------------------------------------------------------------
// vpcs_pkg
// Shared types and codes of the VoIP packet classifier and steering block.
// ----------------------------------------------------------------------------
`default_nettype none

package vpcs_pkg;

  localparam logic [1:0] VOIP_UNKNOWN = 2'd0;
  localparam logic [1:0] VOIP_RTP     = 2'd1;
  localparam logic [1:0] VOIP_RTCP    = 2'd2;
  localparam logic [1:0] VOIP_SIP     = 2'd3;

  localparam logic [1:0] VERDICT_DROP      = 2'd0;
  localparam logic [1:0] VERDICT_PASS      = 2'd1;
  localparam logic [1:0] VERDICT_STEER     = 2'd2;
  localparam logic [1:0] VERDICT_BROADCAST = 2'd3;

  localparam logic [2:0] MODE_RTP_FILTER  = 3'd0;
  localparam logic [2:0] MODE_RTCP_FILTER = 3'd1;
  localparam logic [2:0] MODE_SIP_FILTER  = 3'd2;
  localparam logic [2:0] MODE_VOIP_FILTER = 3'd3;
  localparam logic [2:0] MODE_STEER_RTP   = 3'd4;
  localparam logic [2:0] MODE_STEER_VOIP  = 3'd5;

  localparam logic       REG_VERDICT_MODE = 1'b0;
  localparam logic       REG_LINK_HEADER  = 1'b1;

  localparam logic [2:0] VERDICT_MODE_RESET = MODE_STEER_VOIP;
  localparam logic [7:0] LINK_HEADER_RESET  = 8'd14;

  localparam logic [15:0] ETHER_IPV4     = 16'h0800;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [15:0] PORT_SIP       = 16'd5060;
  localparam logic [15:0] PORT_SIP_TLS   = 16'd5061;
  localparam logic [15:0] PORT_MIN       = 16'd1024;
  localparam logic [7:0]  RTCP_SR        = 8'd200;
  localparam logic [1:0]  RTP_VERSION    = 2'd2;
  localparam logic [8:0]  TRANSPORT_MIN  = 9'd20;

  typedef struct packed {
    logic [15:0] captured_length;
    logic [15:0] ether_type;
    logic [3:0]  ip_header_words;
    logic [7:0]  ip_protocol;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [7:0]  rtp_flag_byte;
    logic [7:0]  rtp_type_byte;
  } item_t;

  typedef struct packed {
    logic [1:0]  voip_type;
    logic [1:0]  verdict;
    logic [31:0] steer_hash;
  } result_t;

  function automatic logic codec_ok(input logic [7:0] c);
    codec_ok = (c < 8'd19) || (c > 8'd95) || (c == 8'd25) || (c == 8'd26) ||
               (c == 8'd28) || ((c >= 8'd31) && (c <= 8'd34));
  endfunction

endpackage

`default_nettype wire

>>> src/vpcs_classify.sv
// ----------------------------------------------------------------------------
// vpcs_classify
// Classification, verdict selection and steering hash for one packet.
// ----------------------------------------------------------------------------
`default_nettype none

module vpcs_classify (
  input  var vpcs_pkg::item_t   item,
  input  var logic [2:0]        verdict_mode,
  input  var logic [7:0]        link_header_length,
  output var vpcs_pkg::result_t result
);

  logic [16:0] cap;
  logic [16:0] need_base;
  logic [16:0] need_full;
  logic        sip_port;
  logic        sp_odd;
  logic        dp_odd;
  logic [1:0]  t;
  logic        steer;
  logic [1:0]  v;
  logic [31:0] sa;
  logic [31:0] da;
  logic [15:0] sp;
  logic [15:0] dp;
  logic [31:0] hash;

  assign cap       = {1'b0, item.captured_length};
  assign need_base = 17'(link_header_length) + 17'(vpcs_pkg::TRANSPORT_MIN);
  assign need_full = need_base + 17'({item.ip_header_words, 2'b00});
  assign sip_port  = (item.dest_port == vpcs_pkg::PORT_SIP) ||
                     (item.source_port == vpcs_pkg::PORT_SIP) ||
                     (item.dest_port == vpcs_pkg::PORT_SIP_TLS) ||
                     (item.source_port == vpcs_pkg::PORT_SIP_TLS);
  assign sp_odd    = item.source_port[0];
  assign dp_odd    = item.dest_port[0];

  always_comb begin
    if (item.ether_type != vpcs_pkg::ETHER_IPV4) begin
      t = vpcs_pkg::VOIP_UNKNOWN;
    end else if (cap < need_base || cap < need_full) begin
      t = vpcs_pkg::VOIP_UNKNOWN;
    end else if (sip_port) begin
      t = vpcs_pkg::VOIP_SIP;
    end else if (item.ip_protocol != vpcs_pkg::PROTO_UDP) begin
      t = vpcs_pkg::VOIP_UNKNOWN;
    end else if (item.rtp_flag_byte[7:6] != vpcs_pkg::RTP_VERSION) begin
      t = vpcs_pkg::VOIP_UNKNOWN;
    end else if (item.dest_port < vpcs_pkg::PORT_MIN ||
                 item.source_port < vpcs_pkg::PORT_MIN) begin
      t = vpcs_pkg::VOIP_UNKNOWN;
    end else if (sp_odd && dp_odd) begin
      t = (item.rtp_type_byte == vpcs_pkg::RTCP_SR) ? vpcs_pkg::VOIP_RTCP
                                                    : vpcs_pkg::VOIP_UNKNOWN;
    end else if (!sp_odd && !dp_odd && !vpcs_pkg::codec_ok(item.rtp_type_byte)) begin
      t = vpcs_pkg::VOIP_UNKNOWN;
    end else begin
      t = vpcs_pkg::VOIP_RTP;
    end
  end

  always_comb begin
    v     = vpcs_pkg::VERDICT_DROP;
    steer = 1'b0;
    case (verdict_mode)
      vpcs_pkg::MODE_RTP_FILTER: begin
        if (t == vpcs_pkg::VOIP_RTP) v = vpcs_pkg::VERDICT_PASS;
      end
      vpcs_pkg::MODE_RTCP_FILTER: begin
        if (t == vpcs_pkg::VOIP_RTCP) v = vpcs_pkg::VERDICT_PASS;
      end
      vpcs_pkg::MODE_SIP_FILTER: begin
        if (t == vpcs_pkg::VOIP_SIP) v = vpcs_pkg::VERDICT_PASS;
      end
      vpcs_pkg::MODE_VOIP_FILTER: begin
        if (t != vpcs_pkg::VOIP_UNKNOWN) v = vpcs_pkg::VERDICT_PASS;
      end
      vpcs_pkg::MODE_STEER_RTP: begin
        steer = (t == vpcs_pkg::VOIP_RTP) || (t == vpcs_pkg::VOIP_RTCP);
      end
      vpcs_pkg::MODE_STEER_VOIP: begin
        steer = (t == vpcs_pkg::VOIP_RTP) || (t == vpcs_pkg::VOIP_RTCP);
        if (t == vpcs_pkg::VOIP_SIP) v = vpcs_pkg::VERDICT_BROADCAST;
      end
      default: begin
        v = vpcs_pkg::VERDICT_DROP;
      end
    endcase
    if (steer) v = vpcs_pkg::VERDICT_STEER;
  end

  // host byte order: addresses reversed, ports swapped
  assign sa = {item.source_address[7:0], item.source_address[15:8],
               item.source_address[23:16], item.source_address[31:24]};
  assign da = {item.dest_address[7:0], item.dest_address[15:8],
               item.dest_address[23:16], item.dest_address[31:24]};
  assign sp = {item.source_port[7:0], item.source_port[15:8]};
  assign dp = {item.dest_port[7:0], item.dest_port[15:8]};

  assign hash = sa ^ (sa >> 8) ^ (sa >> 16) ^ (sa >> 24) ^
                da ^ (da >> 8) ^ (da >> 16) ^ (da >> 24) ^
                32'(sp >> 1) ^ 32'(dp >> 1);

  assign result.voip_type  = t;
  assign result.verdict    = v;
  assign result.steer_hash = steer ? hash : 32'd0;

endmodule

`default_nettype wire

>>> src/voip_packet_classifier_steer.sv
// ----------------------------------------------------------------------------
// voip_packet_classifier_steer
// Classifies packets as unknown, RTP, RTCP or SIP and picks a filter or
// steering verdict, with an XOR fold hash for steered packets.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  input     start, busy            captured_length .. rtp_type_byte
//  result    done (one cycle)       voip_type, verdict, steer_hash
//  config    APB psel/penable       paddr, pwdata, prdata (0: mode, 4: link)
//
//  One packet per cycle; busy stays low. Result strobes on done once the start
//  beat has passed the input register, classify logic and result register.
//  Synchronous reset clears the pipeline valids and loads register defaults.
//  The receiver cannot stall, so nothing back-pressures the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module voip_packet_classifier_steer (
  input  var logic        clk,
  input  var logic        rst,
  input  var logic        start,
  output var logic        busy,
  input  var logic [15:0] captured_length,
  input  var logic [15:0] ether_type,
  input  var logic [3:0]  ip_header_words,
  input  var logic [7:0]  ip_protocol,
  input  var logic [31:0] source_address,
  input  var logic [31:0] dest_address,
  input  var logic [15:0] source_port,
  input  var logic [15:0] dest_port,
  input  var logic [7:0]  rtp_flag_byte,
  input  var logic [7:0]  rtp_type_byte,
  output var logic        done,
  output var logic [1:0]  voip_type,
  output var logic [1:0]  verdict,
  output var logic [31:0] steer_hash,
  input  var logic        psel,
  input  var logic        penable,
  input  var logic        pwrite,
  input  var logic [2:0]  paddr,
  input  var logic [31:0] pwdata,
  output var logic [31:0] prdata,
  output var logic        pready
);

  logic [2:0]        verdict_mode;
  logic [7:0]        link_header_length;
  logic              item_valid;
  vpcs_pkg::item_t   item;
  vpcs_pkg::result_t result_next;
  vpcs_pkg::result_t result;
  logic              accept;
  logic              cfg_write;

  assign busy      = 1'b0;
  assign pready    = 1'b1;
  assign accept    = start && !busy;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      verdict_mode       <= vpcs_pkg::VERDICT_MODE_RESET;
      link_header_length <= vpcs_pkg::LINK_HEADER_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        vpcs_pkg::REG_VERDICT_MODE: verdict_mode       <= pwdata[2:0];
        vpcs_pkg::REG_LINK_HEADER:  link_header_length <= pwdata[7:0];
        default: verdict_mode <= verdict_mode;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      vpcs_pkg::REG_VERDICT_MODE: prdata = 32'(verdict_mode);
      vpcs_pkg::REG_LINK_HEADER:  prdata = 32'(link_header_length);
      default:                    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      item_valid <= accept;
      done       <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.captured_length <= captured_length;
      item.ether_type      <= ether_type;
      item.ip_header_words <= ip_header_words;
      item.ip_protocol     <= ip_protocol;
      item.source_address  <= source_address;
      item.dest_address    <= dest_address;
      item.source_port     <= source_port;
      item.dest_port       <= dest_port;
      item.rtp_flag_byte   <= rtp_flag_byte;
      item.rtp_type_byte   <= rtp_type_byte;
    end
    if (item_valid) begin
      result <= result_next;
    end
  end

  vpcs_classify u_classify (
    .item               (item),
    .verdict_mode       (verdict_mode),
    .link_header_length (link_header_length),
    .result             (result_next)
  );

  assign voip_type  = result.voip_type;
  assign verdict    = result.verdict;
  assign steer_hash = result.steer_hash;

  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |=> ##1 done)
    else $error("result strobe missing two cycles after start beat");

  a_hash_only_steer: assert property (@(posedge clk) disable iff (rst)
    (done && verdict != vpcs_pkg::VERDICT_STEER) |-> steer_hash == 32'd0)
    else $error("nonzero hash on a beat that is not steered");

  a_unknown_drops: assert property (@(posedge clk) disable iff (rst)
    (done && voip_type == vpcs_pkg::VOIP_UNKNOWN) |-> verdict == vpcs_pkg::VERDICT_DROP)
    else $error("unknown packet not dropped");

  a_steer_media: assert property (@(posedge clk) disable iff (rst)
    (done && verdict == vpcs_pkg::VERDICT_STEER) |->
      (voip_type == vpcs_pkg::VOIP_RTP || voip_type == vpcs_pkg::VOIP_RTCP))
    else $error("steer verdict on a packet that is not RTP or RTCP");

endmodule

`default_nettype wire

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the VoIP classifier and steering block. Packets
// go in on the start/busy port. Each one is classified and given a verdict
// by an in-bench predictor. Every done beat is compared in order against
// that prediction. The APB port steps through every verdict mode and a
// range of link header lengths. A short directed set covers length edges,
// SIP ports, version and port bounds, RTCP typing and the codec table.
// Random well-formed and broken packets follow it.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_ITEMS  = 200;
  localparam int DRAIN_CYCLES = 4;
  localparam logic [2:0] ADDR_MODE = {vpcs_pkg::REG_VERDICT_MODE, 2'b00};
  localparam logic [2:0] ADDR_LINK = {vpcs_pkg::REG_LINK_HEADER, 2'b00};
  localparam logic [2:0] MODE_UNUSED = 3'd7;

  class verdict_scoreboard;
    logic [2:0]        mode;
    int                link_len;
    vpcs_pkg::result_t expected_q[$];
    int                errors;
    int                checked;
    int                type_seen[4];

    function new();
      mode     = vpcs_pkg::VERDICT_MODE_RESET;
      link_len = vpcs_pkg::LINK_HEADER_RESET;
      errors   = 0;
      checked  = 0;
      foreach (type_seen[i]) type_seen[i] = 0;
    endfunction

    function logic codec_allowed(logic [7:0] c);
      return c < 8'd19 || c > 8'd95 || c == 8'd25 || c == 8'd26 || c == 8'd28 ||
             (c >= 8'd31 && c <= 8'd34);
    endfunction

    function logic [1:0] packet_type(vpcs_pkg::item_t p);
      int cap;
      int hdr;
      cap = p.captured_length;
      hdr = 4 * int'(p.ip_header_words);
      if (p.ether_type != vpcs_pkg::ETHER_IPV4) return vpcs_pkg::VOIP_UNKNOWN;
      if (cap < link_len + 20) return vpcs_pkg::VOIP_UNKNOWN;
      if (cap < link_len + hdr + 20) return vpcs_pkg::VOIP_UNKNOWN;
      if (p.dest_port == vpcs_pkg::PORT_SIP || p.source_port == vpcs_pkg::PORT_SIP ||
          p.dest_port == vpcs_pkg::PORT_SIP_TLS || p.source_port == vpcs_pkg::PORT_SIP_TLS)
        return vpcs_pkg::VOIP_SIP;
      if (p.ip_protocol != vpcs_pkg::PROTO_UDP) return vpcs_pkg::VOIP_UNKNOWN;
      if (p.rtp_flag_byte[7:6] != vpcs_pkg::RTP_VERSION) return vpcs_pkg::VOIP_UNKNOWN;
      if (p.dest_port < vpcs_pkg::PORT_MIN || p.source_port < vpcs_pkg::PORT_MIN)
        return vpcs_pkg::VOIP_UNKNOWN;
      if (p.dest_port[0] && p.source_port[0])
        return (p.rtp_type_byte == vpcs_pkg::RTCP_SR) ? vpcs_pkg::VOIP_RTCP
                                                       : vpcs_pkg::VOIP_UNKNOWN;
      if (!p.dest_port[0] && !p.source_port[0] && !codec_allowed(p.rtp_type_byte))
        return vpcs_pkg::VOIP_UNKNOWN;
      return vpcs_pkg::VOIP_RTP;
    endfunction

    function logic [31:0] addr_fold(logic [31:0] a);
      logic [31:0] le;
      le = {a[7:0], a[15:8], a[23:16], a[31:24]};
      return le ^ (le >> 8) ^ (le >> 16) ^ (le >> 24);
    endfunction

    function logic [31:0] port_half(logic [15:0] p);
      logic [31:0] sw;
      sw = {16'd0, p[7:0], p[15:8]};
      return sw >> 1;
    endfunction

    function void note_packet(vpcs_pkg::item_t p);
      vpcs_pkg::result_t r;
      logic              steer_it;
      r.voip_type  = packet_type(p);
      r.verdict    = vpcs_pkg::VERDICT_DROP;
      r.steer_hash = '0;
      steer_it     = 1'b0;
      case (mode)
        vpcs_pkg::MODE_RTP_FILTER: begin
          if (r.voip_type == vpcs_pkg::VOIP_RTP) r.verdict = vpcs_pkg::VERDICT_PASS;
        end
        vpcs_pkg::MODE_RTCP_FILTER: begin
          if (r.voip_type == vpcs_pkg::VOIP_RTCP) r.verdict = vpcs_pkg::VERDICT_PASS;
        end
        vpcs_pkg::MODE_SIP_FILTER: begin
          if (r.voip_type == vpcs_pkg::VOIP_SIP) r.verdict = vpcs_pkg::VERDICT_PASS;
        end
        vpcs_pkg::MODE_VOIP_FILTER: begin
          if (r.voip_type != vpcs_pkg::VOIP_UNKNOWN) r.verdict = vpcs_pkg::VERDICT_PASS;
        end
        vpcs_pkg::MODE_STEER_RTP: begin
          steer_it = (r.voip_type == vpcs_pkg::VOIP_RTP ||
                      r.voip_type == vpcs_pkg::VOIP_RTCP);
        end
        vpcs_pkg::MODE_STEER_VOIP: begin
          steer_it = (r.voip_type == vpcs_pkg::VOIP_RTP ||
                      r.voip_type == vpcs_pkg::VOIP_RTCP);
          if (r.voip_type == vpcs_pkg::VOIP_SIP) r.verdict = vpcs_pkg::VERDICT_BROADCAST;
        end
        default: ;
      endcase
      if (steer_it) begin
        r.verdict    = vpcs_pkg::VERDICT_STEER;
        r.steer_hash = addr_fold(p.source_address) ^ addr_fold(p.dest_address) ^
                       port_half(p.source_port) ^ port_half(p.dest_port);
      end
      type_seen[r.voip_type]++;
      expected_q.push_back(r);
    endfunction

    function void check_verdict(vpcs_pkg::result_t got);
      vpcs_pkg::result_t want;
      if (expected_q.size() == 0) begin
        $error("result beat with no packet pending");
        errors++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.voip_type !== want.voip_type) begin
        $error("voip_type: expected %0d, got %0d", want.voip_type, got.voip_type);
        errors++;
      end
      if (got.verdict !== want.verdict) begin
        $error("verdict: expected %0d, got %0d", want.verdict, got.verdict);
        errors++;
      end
      if (got.steer_hash !== want.steer_hash) begin
        $error("steer_hash: expected %h, got %h", want.steer_hash, got.steer_hash);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  vpcs_pkg::item_t   cur;
  logic              done;
  logic [1:0]        voip_type;
  logic [1:0]        verdict;
  logic [31:0]       steer_hash;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [2:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  vpcs_pkg::result_t seen_result;

  verdict_scoreboard board;
  logic idle_on;
  int   link_cfg;
  int   cycles;
  int   settings_run;

  assign seen_result = {voip_type, verdict, steer_hash};

  voip_packet_classifier_steer u_top (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .captured_length (cur.captured_length),
    .ether_type      (cur.ether_type),
    .ip_header_words (cur.ip_header_words),
    .ip_protocol     (cur.ip_protocol),
    .source_address  (cur.source_address),
    .dest_address    (cur.dest_address),
    .source_port     (cur.source_port),
    .dest_port       (cur.dest_port),
    .rtp_flag_byte   (cur.rtp_flag_byte),
    .rtp_type_byte   (cur.rtp_type_byte),
    .done            (done),
    .voip_type       (voip_type),
    .verdict         (verdict),
    .steer_hash      (steer_hash),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && board != null) begin
      if (start && !busy) board.note_packet(cur);
      if (done) board.check_verdict(seen_result);
    end
  end

  function automatic logic [15:0] rand_port(logic parity);
    return {15'($urandom_range(512, 32767)), parity};
  endfunction

  // well-formed RTP/RTCP-shaped packet under the current link length
  function automatic vpcs_pkg::item_t voip_packet(logic [15:0] sp, logic [15:0] dp,
                                                  logic [7:0] tbyte, logic [3:0] ihl,
                                                  int slack);
    vpcs_pkg::item_t p;
    p.ether_type      = vpcs_pkg::ETHER_IPV4;
    p.ip_header_words = ihl;
    p.captured_length = 16'(link_cfg + 4 * int'(ihl) + 20 + slack);
    p.ip_protocol     = vpcs_pkg::PROTO_UDP;
    p.source_address  = $urandom;
    p.dest_address    = $urandom;
    p.source_port     = sp;
    p.dest_port       = dp;
    p.rtp_flag_byte   = {vpcs_pkg::RTP_VERSION, 6'($urandom)};
    p.rtp_type_byte   = tbyte;
    return p;
  endfunction

  function automatic vpcs_pkg::item_t random_packet();
    vpcs_pkg::item_t p;
    int              kind;
    logic [3:0]      ihl;
    int              slack;
    kind  = $urandom_range(0, 99);
    ihl   = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'd5;
    slack = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 1500);
    if (kind < 30) begin
      p = voip_packet(rand_port(1'b0), rand_port(1'b0), 8'($urandom), ihl, slack);
    end else if (kind < 45) begin
      p = voip_packet(rand_port(1'b1), rand_port(1'b0), 8'($urandom), ihl, slack);
      if ($urandom_range(0, 1)) {p.source_port, p.dest_port} = {p.dest_port, p.source_port};
    end else if (kind < 60) begin
      p = voip_packet(rand_port(1'b1), rand_port(1'b1), vpcs_pkg::RTCP_SR, ihl, slack);
    end else if (kind < 70) begin
      p = voip_packet(16'($urandom), 16'($urandom), 8'($urandom), ihl, slack);
      p.ip_protocol = ($urandom_range(0, 1)) ? vpcs_pkg::PROTO_UDP : 8'($urandom);
      if ($urandom_range(0, 1))
        p.source_port = $urandom_range(0, 1) ? vpcs_pkg::PORT_SIP : vpcs_pkg::PORT_SIP_TLS;
      else
        p.dest_port = $urandom_range(0, 1) ? vpcs_pkg::PORT_SIP : vpcs_pkg::PORT_SIP_TLS;
    end else if (kind < 85) begin
      p = voip_packet(rand_port(1'($urandom_range(0, 1))), rand_port(1'($urandom_range(0, 1))),
                      ($urandom_range(0, 1)) ? vpcs_pkg::RTCP_SR : 8'($urandom), ihl, slack);
      case ($urandom_range(0, 6))
        0: p.ether_type = 16'($urandom);
        1: p.captured_length = 16'(link_cfg + 4 * int'(ihl) + 19 - $urandom_range(0, 30));
        2: p.ip_protocol = 8'($urandom);
        3: p.rtp_flag_byte[7:6] = 2'($urandom);
        4: p.source_port = 16'($urandom_range(0, 1023));
        5: p.dest_port = 16'($urandom_range(0, 1024));
        default: p.rtp_type_byte = vpcs_pkg::RTCP_SR + 8'($urandom_range(1, 255));
      endcase
    end else begin
      p = vpcs_pkg::item_t'({$urandom, $urandom, $urandom, $urandom, 28'($urandom)});
      if ($urandom_range(0, 1)) p.ether_type = vpcs_pkg::ETHER_IPV4;
    end
    return p;
  endfunction

  task automatic send_packet(vpcs_pkg::item_t p);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    start <= 1'b1;
    cur   <= p;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(logic [2:0] mode, logic [7:0] link);
    drain();
    apb_write(ADDR_MODE, ($urandom & ~32'h7) | {29'd0, mode});
    apb_write(ADDR_LINK, ($urandom & ~32'hff) | {24'd0, link});
    if (prdata !== {24'd0, link}) begin
      $error("prdata: expected %0d, got %0d", link, prdata);
      board.errors++;
    end
    paddr <= ADDR_MODE;
    @(posedge clk);
    if (prdata !== {29'd0, mode}) begin
      $error("prdata: expected %0d, got %0d", mode, prdata);
      board.errors++;
    end
    board.mode     = mode;
    board.link_len = link;
    link_cfg       = link;
    settings_run++;
  endtask

  task automatic directed_packets();
    vpcs_pkg::item_t p;
    p = voip_packet(16'd2000, 16'd3000, 8'd0, 4'd5, 100);
    p.ether_type = 16'h86dd;
    send_packet(p);
    // short of link + 20, and exactly at link + 20 with a zero header length
    p = voip_packet(16'd2000, 16'd3000, 8'd0, 4'd0, -1);
    send_packet(p);
    p = voip_packet(16'd2000, 16'd3000, 8'd0, 4'd0, 0);
    send_packet(p);
    p = voip_packet(16'd2001, 16'd3000, 8'd77, 4'd15, 0);
    send_packet(p);
    p = voip_packet(16'd2001, 16'd3000, 8'd77, 4'd15, -1);
    send_packet(p);
    p = voip_packet(16'd40000, vpcs_pkg::PORT_SIP, 8'd0, 4'd5, 10);
    p.ip_protocol = 8'd6;
    send_packet(p);
    p = voip_packet(vpcs_pkg::PORT_SIP_TLS, 16'd5, 8'd0, 4'd5, 10);
    p.rtp_flag_byte = 8'h00;
    send_packet(p);
    p = voip_packet(16'd2000, 16'd3000, 8'd0, 4'd5, 10);
    p.ip_protocol = 8'd6;
    send_packet(p);
    p = voip_packet(16'd2000, 16'd3000, 8'd0, 4'd5, 10);
    p.rtp_flag_byte = 8'hc0;
    send_packet(p);
    p = voip_packet(16'd2000, 16'd3000, 8'd0, 4'd5, 10);
    p.rtp_flag_byte = 8'h7f;
    send_packet(p);
    send_packet(voip_packet(16'd1023, 16'd3000, 8'd0, 4'd5, 10));
    send_packet(voip_packet(16'd1024, 16'd1024, 8'd0, 4'd5, 10));
    send_packet(voip_packet(16'd1025, 16'd65535, vpcs_pkg::RTCP_SR, 4'd5, 10));
    send_packet(voip_packet(16'd1025, 16'd65535, 8'd201, 4'd5, 10));
    send_packet(voip_packet(16'd4000, 16'd65534, 8'd18, 4'd5, 10));
    send_packet(voip_packet(16'd4000, 16'd65534, 8'd19, 4'd5, 10));
    send_packet(voip_packet(16'd4000, 16'd65534, 8'd27, 4'd5, 10));
    send_packet(voip_packet(16'd4000, 16'd65534, 8'd34, 4'd5, 10));
    send_packet(voip_packet(16'd4000, 16'd65534, 8'd35, 4'd5, 10));
    send_packet(voip_packet(16'd4000, 16'd65534, 8'd95, 4'd5, 10));
    send_packet(voip_packet(16'd4000, 16'd65534, 8'd96, 4'd5, 10));
    // mixed parity skips the codec table
    send_packet(voip_packet(16'd4001, 16'd4000, 8'd50, 4'd5, 10));
    p = '1;
    send_packet(p);
    p = '0;
    send_packet(p);
  endtask

  initial begin
    logic [2:0] modes[8];
    logic [7:0] links[8];
    clk          = 1'b0;
    rst          = 1'b1;
    start        = 1'b0;
    cur          = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    idle_on      = 1'b1;
    link_cfg     = vpcs_pkg::LINK_HEADER_RESET;
    cycles       = 0;
    settings_run = 1;
    board        = new();
    modes = '{vpcs_pkg::MODE_RTP_FILTER, vpcs_pkg::MODE_RTCP_FILTER,
              vpcs_pkg::MODE_SIP_FILTER, vpcs_pkg::MODE_VOIP_FILTER,
              vpcs_pkg::MODE_STEER_RTP, MODE_UNUSED,
              vpcs_pkg::MODE_STEER_VOIP, vpcs_pkg::MODE_STEER_VOIP};
    links = '{8'd0, 8'd255, 8'd14, 8'd42, 8'd3, 8'd200, 8'd255, 8'd0};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_packets();
    send_packet(random_packet());
    for (int ph = 0; ph < 8; ph++) begin
      configure(modes[ph], (ph == 3) ? 8'($urandom) : links[ph]);
      if (ph == 7) idle_on = 1'b0;
      repeat (PHASE_ITEMS) send_packet(random_packet());
    end
    drain();
    $display("Checked %0d results over %0d register settings, all six modes and one unused",
             board.checked, settings_run);
    $display("Types predicted: unknown %0d, rtp %0d, rtcp %0d, sip %0d",
             board.type_seen[vpcs_pkg::VOIP_UNKNOWN], board.type_seen[vpcs_pkg::VOIP_RTP],
             board.type_seen[vpcs_pkg::VOIP_RTCP], board.type_seen[vpcs_pkg::VOIP_SIP]);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> voip_packet_classifier_steer.f
src/vpcs_pkg.sv
src/vpcs_classify.sv
src/voip_packet_classifier_steer.sv
bench/tb.sv
